// File: hdl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising edge, off while in reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hdl/nli_pkg.sv
// Shared constants, codes and types of the node line incidence lister.
// No dependencies.
package nli_pkg;

    localparam int MAX_REFS_DEF      = 20;
    localparam int LINE_CAPACITY_DEF = 1024;
    localparam int NODE_LIMIT_DEF    = 4096;

    localparam int MODE_W   = 2;
    localparam int NODE_W   = 12;
    localparam int LINE_W   = 11;
    localparam int STATUS_W = 3;
    // wide enough to compare a node against any node limit
    localparam int LIMIT_W  = 17;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LIST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_REF     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MANY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

    // outcome of one compare step of the scan
    typedef struct packed {
        logic hit;   // selected node equals the query
        logic full;  // this hit fills the reference buffer
    } match_t;

endpackage

// File: hdl/nli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/nli_match.sv
// Shared compare step of the scan: picks the begin or end node of a line,
// tests it against the query and advances the reference count. Uses nli_pkg.
module nli_match
    import nli_pkg::*;
#(
    parameter int MAX_REFS = MAX_REFS_DEF,
    localparam int RB_AW   = $clog2(MAX_REFS)
) (
    input  logic [NODE_W-1:0] node_b,
    input  logic [NODE_W-1:0] node_e,
    input  logic              sel_end,
    input  logic [NODE_W-1:0] query,
    input  logic [RB_AW-1:0]  ref_cnt,
    output match_t            result,
    output logic [RB_AW-1:0]  ref_cnt_next
);

    logic [NODE_W-1:0] node_sel;

    always_comb
    begin
        node_sel        = sel_end ? node_e : node_b;
        result.hit      = (node_sel == query);
        result.full     = result.hit && (ref_cnt == RB_AW'(MAX_REFS - 1));
        ref_cnt_next    = result.hit ? (ref_cnt + RB_AW'(1)) : ref_cnt;
    end

endmodule

// File: hdl/node_line_incidence_lister.sv
// Node line incidence lister: load or clear answers in the cycle after accept, one per cycle.
// List: scans the L stored lines (two compare steps per line on one compare
// unit, line store read once per line), then one reference per cycle from the
// buffer. Results cannot be stalled.
// Reset (rst_n, async, active low) empties the store; RAM contents stay.
// Depends on nli_pkg, nli_ram, nli_match and assert_macros.svh.
`include "assert_macros.svh"

module node_line_incidence_lister
    import nli_pkg::*;
#(
    parameter int MAX_REFS      = MAX_REFS_DEF,
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int NODE_LIMIT    = NODE_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // command side: a transaction is taken when start is high and busy low
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic [NODE_W-1:0]   begin_node,
    input  logic [NODE_W-1:0]   end_node,
    input  logic [NODE_W-1:0]   query_node,
    // result side: each result is valid for the single cycle strobe is high
    output logic                strobe,
    output logic [LINE_W-1:0]   line_number,
    output logic                at_end,
    output logic [STATUS_W-1:0] status,
    output logic                last
);

    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);
    localparam int RB_AW  = $clog2(MAX_REFS);
    localparam int RB_DW  = LINE_W + 1;

    // Sequencer states. A line is scanned in two compare steps, begin first,
    // so a loop line on the query is recorded begin-then-end.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,     // first line read in flight
        S_CMP_B,  // compare begin node
        S_CMP_E,  // compare end node, fetch next line
        S_FETCH,  // first buffered reference read in flight
        S_EMIT    // one reference out per cycle
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;     // lines stored
    logic [ADDR_W-1:0]   idx_reg;       // line under scan
    logic [RB_AW-1:0]    nref_reg;      // references collected
    logic [RB_AW-1:0]    k_reg;         // reference being emitted
    logic [NODE_W-1:0]   query_reg;

    logic                strobe_reg;
    logic [LINE_W-1:0]   line_number_reg;
    logic                at_end_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    // line store: {begin, end} per line
    logic                    st_we;
    logic [ADDR_W-1:0]       st_waddr;
    logic [2*NODE_W-1:0]     st_wdata;
    logic                    st_re;
    logic [ADDR_W-1:0]       st_raddr;
    logic [2*NODE_W-1:0]     st_rdata;

    // reference buffer: {line number, at_end}
    logic                    rb_we;
    logic [RB_DW-1:0]        rb_wdata;
    logic                    rb_re;
    logic [RB_AW-1:0]        rb_raddr;
    logic [RB_DW-1:0]        rb_rdata;

    match_t                  match;
    logic [RB_AW-1:0]        nref_next;
    logic                    sel_end;

    logic                    accept;
    logic                    store_full;
    logic                    query_ok;
    logic                    scan_last;
    logic                    emit_last;
    logic [CNT_W-1:0]        line_num_c;
    logic                    one_shot_cmd;

    // Nodes at or above the limit are stored as "no node".
    function automatic logic [NODE_W-1:0] clip_node(input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] r;
        r = (LIMIT_W'(n) < LIMIT_W'(NODE_LIMIT)) ? n : '0;
        return r;
    endfunction

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign store_full = (count_reg >= CNT_W'(LINE_CAPACITY));
    assign query_ok   = (query_node != '0) &&
                        (LIMIT_W'(query_node) < LIMIT_W'(NODE_LIMIT));
    assign line_num_c = CNT_W'(idx_reg) + CNT_W'(1);
    assign scan_last  = (line_num_c == count_reg);
    assign emit_last  = ((k_reg + RB_AW'(1)) == nref_reg);
    assign sel_end    = (state_reg == S_CMP_E);
    // load and clear each end in a single result
    assign one_shot_cmd = accept && ((mode == MODE_LOAD) || (mode == MODE_CLEAR));

    // store and buffer port control
    always_comb
    begin
        st_we    = accept && (mode == MODE_LOAD) && !store_full;
        st_waddr = ADDR_W'(count_reg);
        st_wdata = {clip_node(begin_node), clip_node(end_node)};
        st_re    = 1'b0;
        st_raddr = idx_reg;
        rb_we    = 1'b0;
        rb_wdata = {LINE_W'(line_num_c), sel_end};
        rb_re    = 1'b0;
        rb_raddr = '0;
        case (state_reg)
            S_RD:
            begin
                st_re = 1'b1;
            end
            S_CMP_B:
            begin
                rb_we = match.hit;
            end
            S_CMP_E:
            begin
                rb_we    = match.hit;
                st_re    = !scan_last;
                st_raddr = idx_reg + ADDR_W'(1);
            end
            S_FETCH:
            begin
                rb_re = 1'b1;
            end
            S_EMIT:
            begin
                rb_re    = !emit_last;
                rb_raddr = k_reg + RB_AW'(1);
            end
            default:
            begin
                rb_we = 1'b0;
            end
        endcase
    end

    nli_ram #(
        .WIDTH (2*NODE_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_en   (st_re),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    nli_ram #(
        .WIDTH (RB_DW),
        .DEPTH (MAX_REFS)
    ) u_ref_buf (
        .clk     (clk),
        .wr_en   (rb_we),
        .wr_addr (nref_reg),
        .wr_data (rb_wdata),
        .rd_en   (rb_re),
        .rd_addr (rb_raddr),
        .rd_data (rb_rdata)
    );

    nli_match #(
        .MAX_REFS (MAX_REFS)
    ) u_match (
        .node_b       (st_rdata[2*NODE_W-1:NODE_W]),
        .node_e       (st_rdata[NODE_W-1:0]),
        .sel_end      (sel_end),
        .query        (query_reg),
        .ref_cnt      (nref_reg),
        .result       (match),
        .ref_cnt_next (nref_next)
    );

    // sequencer, counters and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            nref_reg        <= '0;
            k_reg           <= '0;
            query_reg       <= '0;
            strobe_reg      <= 1'b0;
            line_number_reg <= '0;
            at_end_reg      <= 1'b0;
            status_reg      <= ST_REF;
            last_reg        <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        line_number_reg <= '0;
                        at_end_reg      <= 1'b0;
                        last_reg        <= 1'b1;
                        case (mode)
                            MODE_LOAD:
                            begin
                                strobe_reg <= 1'b1;
                                if (store_full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    status_reg      <= ST_LOADED;
                                    line_number_reg <= LINE_W'(count_reg + CNT_W'(1));
                                    count_reg       <= count_reg + CNT_W'(1);
                                end
                            end
                            MODE_CLEAR:
                            begin
                                strobe_reg <= 1'b1;
                                status_reg <= ST_CLEARED;
                                count_reg  <= '0;
                            end
                            MODE_LIST:
                            begin
                                if (!query_ok || (count_reg == '0))
                                begin
                                    strobe_reg <= 1'b1;
                                    status_reg <= ST_NONE;
                                end
                                else
                                begin
                                    query_reg <= query_node;
                                    idx_reg   <= '0;
                                    nref_reg  <= '0;
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                                // unused mode: no result; line number, at_end and last are cleared
                                last_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP_B;
                end
                S_CMP_B:
                begin
                    nref_reg <= nref_next;
                    if (match.full)
                    begin
                        strobe_reg      <= 1'b1;
                        status_reg      <= ST_MANY;
                        line_number_reg <= '0;
                        at_end_reg      <= 1'b0;
                        last_reg        <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CMP_E;
                    end
                end
                S_CMP_E:
                begin
                    nref_reg <= nref_next;
                    line_number_reg <= '0;
                    at_end_reg      <= 1'b0;
                    last_reg        <= 1'b1;
                    if (match.full)
                    begin
                        strobe_reg <= 1'b1;
                        status_reg <= ST_MANY;
                        state_reg  <= S_IDLE;
                    end
                    else if (scan_last)
                    begin
                        if (nref_next == '0)
                        begin
                            strobe_reg <= 1'b1;
                            status_reg <= ST_NONE;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= '0;
                            state_reg <= S_FETCH;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + ADDR_W'(1);
                        state_reg <= S_CMP_B;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    strobe_reg      <= 1'b1;
                    status_reg      <= ST_REF;
                    line_number_reg <= rb_rdata[RB_DW-1:1];
                    at_end_reg      <= rb_rdata[0];
                    last_reg        <= emit_last;
                    k_reg           <= k_reg + RB_AW'(1);
                    if (emit_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe      = strobe_reg;
    assign line_number = line_number_reg;
    assign at_end      = at_end_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    // load and clear answer in the very next cycle with a single result
    `ASSERT_ALWAYS(a_single_answer, one_shot_cmd |=> (strobe && last), "load/clear not answered")
    // the store never counts past its capacity
    `ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(LINE_CAPACITY), "line count past capacity")
    // anything other than a reference ends its transaction
    `ASSERT_ALWAYS(a_status_last, (strobe && status != ST_REF) |-> last, "non-reference, no last")
    // a reference list comes out back to back
    `ASSERT_ALWAYS(a_list_gapless, (strobe && !last) |=> strobe, "gap inside a reference list")

endmodule
